>>> rtl/decimal_number_parser_assert.svh
// Assertion macros shared by the decimal number parser modules.
// Each macro expects signals named clk and rst in the including scope.
`ifndef DECIMAL_NUMBER_PARSER_ASSERT_SVH
`define DECIMAL_NUMBER_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DNP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decimal_number_parser: assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define DNP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decimal_number_parser: assertion failed");

`endif

>>> rtl/dnp_pkg.sv
// Shared types and constants for the decimal number parser.
// No dependencies; used by dnp_div and decimal_number_parser.
package dnp_pkg;

  localparam int MANT_W = 31;
  localparam int FD_W   = 4;
  localparam int DEN_W  = 50;
  localparam int VAL_W  = 48;
  localparam int CNT_W  = 8;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [FD_W-1:0]   FD_MAX   = 4'd15;
  localparam logic [CNT_W-1:0]  CNT_MAX  = 8'd255;
  localparam logic [MANT_W-1:0] MANT_MAX = 31'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]  VAL_MAX  = 48'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic busy;
    logic done;
  } dnp_div_stat_t;

  // Ten to the power n, for n up to fifteen.
  function automatic logic [DEN_W-1:0] pow10(input logic [FD_W-1:0] n);
    logic [DEN_W-1:0] r;
    case (n)
      4'd0:    r = 50'd1;
      4'd1:    r = 50'd10;
      4'd2:    r = 50'd100;
      4'd3:    r = 50'd1000;
      4'd4:    r = 50'd10000;
      4'd5:    r = 50'd100000;
      4'd6:    r = 50'd1000000;
      4'd7:    r = 50'd10000000;
      4'd8:    r = 50'd100000000;
      4'd9:    r = 50'd1000000000;
      4'd10:   r = 50'd10000000000;
      4'd11:   r = 50'd100000000000;
      4'd12:   r = 50'd1000000000000;
      4'd13:   r = 50'd10000000000000;
      4'd14:   r = 50'd100000000000000;
      default: r = 50'd1000000000000000;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/dnp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on dnp_pkg and decimal_number_parser_assert.svh.
`include "decimal_number_parser_assert.svh"

module dnp_div
  import dnp_pkg::*;
#(
  parameter int NW = 51,
  parameter int DW = 50
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output dnp_div_stat_t stat,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic          done;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [NW-1:0] shreg;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // Remainder stays below the divisor, so the trial value fits in DW+1 bits.
  assign trial = {rem, shreg[NW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(NW);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      dvs   <= den;
      rem   <= '0;
    end else if (cnt != '0) begin
      shreg <= {shreg[NW-2:0], ge};
      rem   <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign quo       = shreg;

  `DNP_ASSERT_IMP(a_start_when_idle, start, !stat.busy)
  `DNP_ASSERT_NXT(a_done_after_final_step, stat.busy && cnt == CW'(1), stat.done)
  `DNP_ASSERT_IMP(a_done_is_idle, stat.done, !stat.busy)

endmodule

>>> rtl/decimal_number_parser.sv
// Streaming ASCII decimal parser: top level with the character scanner and sequencer.
// Depends on dnp_pkg, dnp_div and decimal_number_parser_assert.svh.
//
// Usage: characters of a text field arrive one request at a time on the char
// channel (ch, last, char_valid/char_ready). Leading spaces are skipped, then any
// other character (a sign, a point, a digit or anything else) opens the number, and digits plus one point extend it.
// A character that does not extend the number ends it and is dropped uncounted;
// last, or reaching MAX_LEN consumed characters, ends it after that character.
// Each end produces one result request on the res channel (found, value as
// signed fixed point with FRAC_BITS fraction bits rounded to nearest, chars_used,
// overflow), handshaken with res_valid/res_ready.
// Throughput: a character that does not end a number is taken without a stall and
// char_ready stays high. An ending character drops char_ready while the divider
// scales the mantissa by a power of ten, one quotient bit per cycle; char_ready
// returns in the same cycle that the result shows up on the res channel.
// Stall: a result waiting on res_ready does not block new characters; only a
// second result waits in the sequencer until the output register frees up.
// Reset (rst, synchronous): clears the scanner, the sequencer and res_valid.
`include "decimal_number_parser_assert.svh"

module decimal_number_parser
  import dnp_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int MAX_LEN   = 255
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    char_valid,
  output logic                    char_ready,
  input  logic [7:0]              ch,
  input  logic                    last,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic                    found,
  output logic signed [VAL_W-1:0] value,
  output logic [CNT_W-1:0]        chars_used,
  output logic                    overflow
);

  // Numerator width: shifted mantissa plus half the largest divisor.
  localparam int NW = (MANT_W + FRAC_BITS >= DEN_W) ? MANT_W + FRAC_BITS + 1 : DEN_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state;

  // Scanner state.
  logic              phase;
  logic              negative;
  logic              in_frac;
  logic [MANT_W-1:0] mant;
  logic              digit_seen;
  logic [FD_W-1:0]   frac_digits;
  logic [CNT_W-1:0]  consumed;
  logic              saturated;

  logic              phase_next;
  logic              negative_next;
  logic              in_frac_next;
  logic [MANT_W-1:0] mant_next;
  logic              digit_seen_next;
  logic [FD_W-1:0]   frac_digits_next;
  logic [CNT_W-1:0]  consumed_next;
  logic              saturated_next;

  logic              is_dig;
  logic              take;
  logic              term;
  logic              count_it;
  logic              emit_now;
  logic [MANT_W+3:0] prod;

  logic               accept;
  logic               out_free;
  logic               div_start;
  dnp_div_stat_t      div_stat;
  logic [NW-1:0]      num;
  logic [DEN_W-1:0]   den;
  logic [NW-1:0]      quo;
  logic               mag_ovf;
  logic [VAL_W-1:0]   mag;
  logic [VAL_W-1:0]   val;

  assign char_ready = (state == S_IDLE);
  assign accept     = char_valid && char_ready;
  assign out_free   = !res_valid || res_ready;
  assign div_start  = (state == S_LOAD);

  // Mantissa times ten plus the new digit; digits 0..9 sit in the low nibble.
  assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign prod   = ((MANT_W + 4)'(mant) << 3) + ((MANT_W + 4)'(mant) << 1)
                + (MANT_W + 4)'(ch[3:0]);

  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    in_frac_next     = in_frac;
    mant_next        = mant;
    digit_seen_next  = digit_seen;
    frac_digits_next = frac_digits;
    saturated_next   = saturated;
    take             = 1'b0;
    term             = 1'b0;
    count_it         = 1'b0;

    if (!phase) begin
      if (ch == CH_SPACE) begin
        count_it = 1'b1;
      end else begin
        take       = 1'b1;
        phase_next = 1'b1;
      end
    end else if (is_dig || (ch == CH_POINT && !in_frac)) begin
      take = 1'b1;
    end else begin
      term = 1'b1;
    end

    if (take) begin
      count_it = 1'b1;
      if (ch == CH_MINUS) begin
        negative_next = 1'b1;
      end else if (ch == CH_POINT) begin
        in_frac_next = 1'b1;
      end else if (is_dig) begin
        digit_seen_next = 1'b1;
        if (prod > (MANT_W + 4)'(MANT_MAX)) begin
          mant_next      = MANT_MAX;
          saturated_next = 1'b1;
        end else begin
          mant_next = prod[MANT_W-1:0];
        end
        if (in_frac && frac_digits != FD_MAX) begin
          frac_digits_next = frac_digits + FD_W'(1);
        end
      end
    end

    consumed_next = (count_it && consumed != CNT_MAX) ? consumed + CNT_W'(1) : consumed;
    emit_now      = term || last || (consumed_next >= CNT_W'(MAX_LEN));
  end

  // Rounded scaling: (mantissa << FRAC_BITS + den / 2) / den.
  assign den = pow10(frac_digits);
  assign num = (NW'(mant) << FRAC_BITS) + NW'(den >> 1);

  dnp_div #(
    .NW (NW),
    .DW (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .stat  (div_stat),
    .quo   (quo)
  );

  // Saturate the magnitude to the positive range, then apply the sign.
  assign mag_ovf = |quo[NW-1:VAL_W-1];
  assign mag     = mag_ovf ? VAL_MAX : {1'b0, quo[VAL_W-2:0]};
  assign val     = negative ? (VAL_W'(0) - mag) : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      phase       <= 1'b0;
      negative    <= 1'b0;
      in_frac     <= 1'b0;
      mant        <= '0;
      digit_seen  <= 1'b0;
      frac_digits <= '0;
      consumed    <= '0;
      saturated   <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            phase       <= phase_next;
            negative    <= negative_next;
            in_frac     <= in_frac_next;
            mant        <= mant_next;
            digit_seen  <= digit_seen_next;
            frac_digits <= frac_digits_next;
            consumed    <= consumed_next;
            saturated   <= saturated_next;
            if (emit_now) begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res_valid   <= 1'b1;
            state       <= S_IDLE;
            phase       <= 1'b0;
            negative    <= 1'b0;
            in_frac     <= 1'b0;
            mant        <= '0;
            digit_seen  <= 1'b0;
            frac_digits <= '0;
            consumed    <= '0;
            saturated   <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload; with no digit the mantissa is zero, so the value is zero too.
  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      found      <= digit_seen;
      value      <= val;
      chars_used <= consumed;
      overflow   <= saturated || mag_ovf;
    end
  end

  `DNP_ASSERT_IMP(a_done_in_div, div_stat.done, state == S_DIV)
  `DNP_ASSERT_NXT(a_load_starts_div, state == S_LOAD, div_stat.busy)
  `DNP_ASSERT_IMP(a_no_digit_zero, res_valid && !found, value == '0)
  `DNP_ASSERT_NXT(a_end_blocks_input, accept && emit_now, !char_ready)

endmodule

>>> tb/sv/decimal_number_parser_tb.sv
// Self-checking testbench for decimal_number_parser: character requests in, parse results out.
// Depends on dnp_pkg and the parser RTL; it predicts every result with its own scanner model.
`timescale 1ns / 1ps

module decimal_number_parser_tb;
  import dnp_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_LEN     = 255;
  localparam int STIM_CHARS  = 1420;
  localparam int SETTLE      = 120;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_GAP     = 18;

  // One character request as the sender will offer it.
  typedef struct {
    logic [7:0] ch;
    logic       last;
    int         gap;
    bit         drain;
  } char_req_t;

  // One parse result, laid out like the result port fields.
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] chars_used;
    logic             overflow;
  } parse_result_t;

  // Our own copy of the scanner state.
  typedef struct packed {
    logic              in_number;
    logic              negative;
    logic              in_fraction;
    logic [MANT_W-1:0] mantissa;
    logic              digit_seen;
    logic [FD_W-1:0]   frac_digits;
    logic [CNT_W-1:0]  consumed;
    logic              saturated;
  } scan_state_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    char_valid = 1'b0;
  logic                    char_ready;
  logic [7:0]              ch = 8'h00;
  logic                    last = 1'b0;
  logic                    res_valid;
  logic                    res_ready = 1'b0;
  logic                    found;
  logic signed [VAL_W-1:0] value;
  logic [CNT_W-1:0]        chars_used;
  logic                    overflow;

  char_req_t     pending_chars[$];
  parse_result_t expected_results[$];
  scan_state_t   scan = '0;
  char_req_t     next_req;
  parse_result_t want;

  bit calm_sender   = 1'b0;
  bit calm_receiver = 1'b0;
  bit drain_next    = 1'b0;

  int total_chars    = 0;
  int chars_taken    = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int empty_count    = 0;
  int overflow_count = 0;
  int negative_count = 0;
  int stall_left     = 0;
  int cycle_count    = 0;

  decimal_number_parser #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_LEN  (MAX_LEN)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .ch        (ch),
    .last      (last),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .found     (found),
    .value     (value),
    .chars_used(chars_used),
    .overflow  (overflow)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
  end

  // ---------------------------------------------------------------------------
  // Scanner prediction. Each accepted character request goes through here, and
  // whenever a number closes, the expected result is queued.
  // ---------------------------------------------------------------------------
  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Consumes one character that belongs to the number.
  function automatic void absorb_char(logic [7:0] c);
    longint unsigned m;
    if (c == CH_MINUS) begin
      scan.negative = 1'b1;
    end else if (c == CH_POINT) begin
      scan.in_fraction = 1'b1;
    end else if (is_digit(c)) begin
      m = 64'(scan.mantissa) * 10 + 64'(c - CH_ZERO);
      scan.digit_seen = 1'b1;
      // The mantissa sticks at its top value once it has run over.
      if (m > 64'(MANT_MAX)) begin
        m = 64'(MANT_MAX);
        scan.saturated = 1'b1;
      end
      scan.mantissa = MANT_W'(m);
      if (scan.in_fraction && scan.frac_digits < FD_MAX) scan.frac_digits++;
    end
    if (scan.consumed < CNT_MAX) scan.consumed++;
  endfunction

  // Scales the mantissa down by ten per fraction digit, rounds to nearest
  // (ties away from zero), applies the sign, and starts over.
  function automatic void close_number();
    parse_result_t r;
    longint unsigned scale;
    longint unsigned mag;
    int k;
    r.found = scan.digit_seen;
    r.value = '0;
    r.chars_used = scan.consumed;
    r.overflow = scan.saturated;
    if (scan.digit_seen) begin
      scale = 1;
      for (k = 0; k < scan.frac_digits; k++) scale = scale * 10;
      mag = ((64'(scan.mantissa) << FRAC_BITS) + scale / 2) / scale;
      if (mag > 64'(VAL_MAX)) begin
        mag = 64'(VAL_MAX);
        r.overflow = 1'b1;
      end
      // A negative zero comes out as plain zero here, since -0 is 0.
      r.value = scan.negative ? VAL_W'(-mag) : VAL_W'(mag);
    end
    expected_results.push_back(r);
    scan = '0;
  endfunction

  function automatic void scan_char(logic [7:0] c, logic fin);
    if (!scan.in_number) begin
      // Leading spaces are only counted; anything else opens the number.
      if (c == CH_SPACE) begin
        if (scan.consumed < CNT_MAX) scan.consumed++;
      end else begin
        absorb_char(c);
        scan.in_number = 1'b1;
      end
    end else if (is_digit(c) || (c == CH_POINT && !scan.in_fraction)) begin
      absorb_char(c);
    end else begin
      // The terminator closes the number and is dropped, even with last set.
      close_number();
      return;
    end
    if (fin || scan.consumed >= MAX_LEN) close_number();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction, all done at time zero.
  // ---------------------------------------------------------------------------
  function automatic void add_char(logic [7:0] c, bit fin);
    char_req_t r;
    r.ch = c;
    r.last = fin;
    r.drain = drain_next;
    r.gap = calm_sender ? 0 : $urandom_range(0, MAX_GAP);
    drain_next = 1'b0;
    // Stretches with no idle cycles at all come and go.
    if ($urandom_range(0, 59) == 0) calm_sender = !calm_sender;
    pending_chars.push_back(r);
  endfunction

  function automatic void add_text(string s, bit fin);
    int k;
    for (k = 0; k < s.len(); k++) add_char(s[k], fin && k == s.len() - 1);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  // Mostly well-formed numbers with random content; some raw noise.
  function automatic void add_random_number();
    int unsigned n;
    int unsigned k;
    int unsigned start;
    logic [7:0] c;
    start = pending_chars.size();
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) add_char(8'($urandom_range(0, 255)), k == n - 1);
      return;
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
    repeat (n) add_char(CH_SPACE, 1'b0);
    if ($urandom_range(0, 2) == 0) add_char(CH_MINUS, 1'b0);
    // Now and then enough integer digits to run the mantissa over.
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
    repeat (n) add_char(rand_digit(), 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      add_char(CH_POINT, 1'b0);
      // Occasionally a fraction longer than the digit counter can hold.
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
      repeat (n) add_char(rand_digit(), 1'b0);
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       c = CH_SPACE;
        1:       c = CH_MINUS;
        default: begin
          do c = 8'($urandom_range(0, 255)); while (is_digit(c) || c == CH_POINT);
        end
      endcase
      add_char(c, 1'($urandom_range(0, 1)));
    end else if (pending_chars.size() > start) begin
      pending_chars[$].last = 1'b1;
    end else begin
      add_char(rand_digit(), 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers character requests from the pending queue. A request stays
  // up, unchanged, until the parser takes it; idle gaps are only inserted
  // between requests.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || char_ready) begin
      if (char_valid) begin
        scan_char(ch, last);
        chars_taken++;
      end
      if (pending_chars.size() == 0) begin
        char_valid <= 1'b0;
      end else if (pending_chars[0].gap > 0) begin
        pending_chars[0].gap--;
        char_valid <= 1'b0;
      end else if (pending_chars[0].drain && expected_results.size() != 0) begin
        // Hold back until every outstanding result has been delivered.
        char_valid <= 1'b0;
      end else begin
        next_req = pending_chars.pop_front();
        ch <= next_req.ch;
        last <= next_req.last;
        char_valid <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes result requests, checks each field against the oldest
  // prediction, and decides how long to hold res_ready low before the next one.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && res_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: found=%0d value=%0d chars=%0d",
                                    found, value, chars_used));
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found)
            report_mismatch($sformatf("result %0d found %0d, expected %0d",
                                      results_seen, found, want.found));
          if (value !== want.value)
            report_mismatch($sformatf("result %0d value %0d, expected %0d",
                                      results_seen, value, $signed(want.value)));
          if (chars_used !== want.chars_used)
            report_mismatch($sformatf("result %0d chars_used %0d, expected %0d",
                                      results_seen, chars_used, want.chars_used));
          if (overflow !== want.overflow)
            report_mismatch($sformatf("result %0d overflow %0d, expected %0d",
                                      results_seen, overflow, want.overflow));
          if (!want.found) empty_count++;
          if (want.overflow) overflow_count++;
          if (want.value[VAL_W-1]) negative_count++;
        end
        if ($urandom_range(0, 24) == 0) calm_receiver = !calm_receiver;
        // Two long hold-offs let the parser back up until it stalls its input.
        if (results_seen == 30) stall_left = 1500;
        else if (results_seen == 500) stall_left = 600;
        else stall_left = calm_receiver ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset, and the end of the run.
  // ---------------------------------------------------------------------------
  initial begin
    int string_idx;

    // Directed part: signs, points, lone spaces, a terminator that carries
    // last, a repeated minus, a second point, and the extreme character codes.
    add_text("  -1.5", 1'b1);
    add_text("7;", 1'b1);
    add_text("--", 1'b0);
    add_text(".", 1'b1);
    add_text("   ", 1'b1);
    add_text("-0", 1'b1);
    add_text("1.2.3", 1'b1);
    add_char(8'hFF, 1'b1);
    add_char(8'h00, 1'b0);
    add_text("5", 1'b1);

    // Random part, with two strings that run into the length bound: one of
    // spaces only, one whose digits also saturate the mantissa.
    string_idx = 0;
    while (pending_chars.size() < STIM_CHARS) begin
      if (string_idx == 10 || string_idx == 70) drain_next = 1'b1;
      if (string_idx == 25) begin
        repeat (260) add_char(CH_SPACE, 1'b0);
      end else if (string_idx == 90) begin
        repeat (240) add_char(CH_SPACE, 1'b0);
        repeat (20) add_char(rand_digit(), 1'b0);
      end else begin
        add_random_number();
      end
      string_idx++;
    end
    // A final digit with last closes whatever is still open.
    add_text("1", 1'b1);
    total_chars = pending_chars.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while ((chars_taken < total_chars || expected_results.size() != 0) &&
           cycle_count < CYCLE_LIMIT)
      @(posedge clk);

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("Verification failed");
    end else begin
      // Any stray result after this point is caught by the monitor.
      repeat (SETTLE) @(posedge clk);
      $display("Sent %0d characters and checked %0d parse results in %0d cycles.",
               chars_taken, results_seen, cycle_count);
      $display("Of those, %0d had no digits, %0d overflowed, %0d were negative; %0d mismatches.",
               empty_count, overflow_count, negative_count, mismatches);
      if (mismatches == 0 && expected_results.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule
